FILE: design/periodic_runnable_dispatcher_top_macros.svh
// Assertion macros shared by the dispatcher checker.
// Each macro expands to one labeled concurrent assertion on clock and reset.
`ifndef PERIODIC_RUNNABLE_DISPATCHER_TOP_MACROS_SVH
`define PERIODIC_RUNNABLE_DISPATCHER_TOP_MACROS_SVH
// Same-cycle implication.
`define PRD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define PRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: design/prd_pkg.sv
// Types and codes shared by the periodic runnable dispatcher.
// No dependencies; prd_front, prd_back, the top level and prd_checker import it.
`timescale 1ns / 1ps
package prd_pkg;
   localparam int GROUP_LIMIT = 16;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_LOAD  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DISABLED = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_ENABLE         = 2'd0,
      CSR_SIGNAL_COUNT   = 2'd1,
      CSR_RUNNABLE_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_STATUS,
      CMD_TICK,
      CMD_LOAD,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_LOAD_MOD,
      BS_READ,
      BS_DUE,
      BS_SCAN,
      BS_EMIT
   } back_state_type;

   typedef struct packed {
      logic       enable;
      logic [6:0] signal_count;
      logic [4:0] runnable_count;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type kind;
      status_type   status;
      logic [5:0]   signal_id;
      logic [31:0]  write_value;
      logic [3:0]   entry_index;
      logic [15:0]  entry_period;
      logic [7:0]   entry_priority;
      logic [7:0]   entry_group;
      logic         entry_present;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] read_value;
      logic        fire_valid;
      logic [3:0]  fire_index;
      logic        checkpoint_valid;
      logic [3:0]  checkpoint_group;
      logic        last;
   } rsp_type;
endpackage

FILE: design/prd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module prd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/prd_fifo.sv
// Small register FIFO used for the command queue and the result queue.
// No dependencies.
`timescale 1ns / 1ps
module prd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule

FILE: design/prd_modu.sv
// Bit-serial remainder unit: 32-bit dividend modulo a 16-bit divisor.
// No dependencies; one quotient bit per cycle.
`timescale 1ns / 1ps
module prd_modu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] remainder
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] rem_ff, rem_in;
   logic [16:0] trial;
   logic [16:0] diff;

   assign trial = {rem_ff, dvd_ff[31]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // Restoring step: the trial value stays below twice the divisor.
         rem_in = (trial >= {1'b0, div_ff}) ? diff[15:0] : trial[15:0];
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

FILE: design/prd_front.sv
// Front end: configuration registers and classification of incoming items.
// Depends on prd_pkg; feeds the command queue in front of prd_back.
`timescale 1ns / 1ps
module prd_front import prd_pkg::*; #(
   parameter int MAX_SIGNALS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_write_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_signal_id,
   input  logic [31:0] req_write_value,
   input  logic [3:0]  req_entry_index,
   input  logic [15:0] req_entry_period,
   input  logic [7:0]  req_entry_priority,
   input  logic [7:0]  req_entry_group,
   input  logic        req_entry_present,
   output cfg_type     cfg,
   output cmd_type     cmd,
   output logic        cmd_push,
   input  logic        cmd_full
);
   cfg_type cfg_ff, cfg_in;
   logic    sid_bad;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:         cfg_in.enable         = csr_write_data[0];
            CSR_SIGNAL_COUNT:   cfg_in.signal_count   = csr_write_data;
            CSR_RUNNABLE_COUNT: cfg_in.runnable_count = csr_write_data[4:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign sid_bad = ({1'b0, req_signal_id} >= cfg_ff.signal_count) ||
                    (32'(req_signal_id) >= MAX_SIGNALS);

   // Everything that can be decided from the item and the registers alone is
   // settled here, so the back end only sees work it must carry out.
   always_comb begin
      cmd.kind           = CMD_STATUS;
      cmd.status         = ST_OK;
      cmd.signal_id      = req_signal_id;
      cmd.write_value    = req_write_value;
      cmd.entry_index    = req_entry_index;
      cmd.entry_period   = req_entry_period;
      cmd.entry_priority = req_entry_priority;
      cmd.entry_group    = req_entry_group;
      cmd.entry_present  = req_entry_present;
      unique case (opcode_type'(req_opcode))
         OP_TICK: begin
            if (cfg_ff.enable) begin
               cmd.kind = CMD_TICK;
            end else begin
               cmd.status = ST_DISABLED;
            end
         end
         OP_LOAD: begin
            cmd.kind = CMD_LOAD;
         end
         OP_WRITE, OP_READ: begin
            priority if (!cfg_ff.enable) begin
               cmd.status = ST_DISABLED;
            end else if (sid_bad) begin
               cmd.status = ST_RANGE;
            end else begin
               cmd.kind = (opcode_type'(req_opcode) == OP_WRITE) ? CMD_WRITE : CMD_READ;
            end
         end
      endcase
   end

   assign cmd_push = req_push && !cmd_full;
   assign req_full = cmd_full;
   assign cfg      = cfg_ff;
endmodule

FILE: design/prd_back.sv
// Back end: signal store, runnable table, tick counter and dispatch sequencer.
// Depends on prd_pkg, prd_ram and prd_modu.
`timescale 1ns / 1ps
module prd_back import prd_pkg::*; #(
   parameter int MAX_SIGNALS   = 64,
   parameter int MAX_RUNNABLES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   output rsp_type rsp,
   output logic    rsp_push,
   input  logic    rsp_full
);
   localparam int NR  = (MAX_RUNNABLES < 16) ? MAX_RUNNABLES : 16;
   localparam int TW  = (NR > 1) ? $clog2(NR) : 1;
   localparam int SAW = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;

   back_state_type state_ff, state_in;
   logic [31:0]    tick_ff, tick_in;

   logic [15:0] period_ff [NR];
   logic [7:0]  prio_ff   [NR];
   logic [7:0]  group_ff  [NR];
   logic [15:0] phase_ff  [NR];
   logic [NR-1:0] present_ff;
   logic [NR-1:0] due_ff;
   logic [15:0]   seen_ff;
   logic [TW-1:0] load_idx_ff;
   logic [TW-1:0] scan_idx_ff;
   logic [TW-1:0] best_ff;
   logic [7:0]    best_prio_ff;
   logic          found_ff;
   logic [MAX_SIGNALS-1:0] sig_valid_ff;
   logic          rd_valid_ff;

   logic          ram_we, ram_re;
   logic [SAW-1:0] sig_addr;
   logic [31:0]   ram_rdata;
   logic          tbl_we, phase_zero, phase_from_mod, tick_go, due_load;
   logic          scan_step, rescan, mark_seen;
   logic          mod_start, mod_done;
   logic [15:0]   mod_rem;
   logic [TW-1:0] tbl_idx;
   logic          idx_ok;
   logic          cand;
   logic [7:0]    best_group;
   logic          ckpt;
   logic [NR-1:0] remaining;

   assign sig_addr   = SAW'(cmd.signal_id);
   assign tbl_idx    = TW'(cmd.entry_index);
   assign idx_ok     = (32'(cmd.entry_index) < NR);
   assign cand       = due_ff[scan_idx_ff] &&
                       (!found_ff || (prio_ff[scan_idx_ff] > best_prio_ff));
   assign best_group = group_ff[best_ff];
   assign ckpt       = (32'(best_group) < GROUP_LIMIT) && !seen_ff[best_group[3:0]];
   assign remaining  = due_ff & ~(NR'(1) << best_ff);

   prd_ram #(.WIDTH(32), .DEPTH(MAX_SIGNALS)) u_sig_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (sig_addr),
      .wr_data (cmd.write_value),
      .rd_en   (ram_re),
      .rd_addr (sig_addr),
      .rd_data (ram_rdata)
   );

   prd_modu u_modu (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (tick_ff),
      .divisor   (cmd.entry_period),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      tick_in        = tick_ff;
      cmd_pop        = 1'b0;
      rsp_push       = 1'b0;
      rsp            = '0;
      rsp.status     = ST_OK;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      tbl_we         = 1'b0;
      phase_zero     = 1'b0;
      phase_from_mod = 1'b0;
      mod_start      = 1'b0;
      tick_go        = 1'b0;
      due_load       = 1'b0;
      scan_step      = 1'b0;
      rescan         = 1'b0;
      mark_seen      = 1'b0;
      unique case (state_ff)
         BS_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_STATUS: begin
                     rsp_push   = 1'b1;
                     rsp.status = cmd.status;
                     rsp.last   = 1'b1;
                  end
                  CMD_WRITE: begin
                     ram_we   = 1'b1;
                     rsp_push = 1'b1;
                     rsp.last = 1'b1;
                  end
                  CMD_READ: begin
                     ram_re   = 1'b1;
                     state_in = BS_READ;
                  end
                  CMD_LOAD: begin
                     rsp_push = 1'b1;
                     rsp.last = 1'b1;
                     if (idx_ok) begin
                        tbl_we = 1'b1;
                        // The entry's phase must match the current count.
                        if (cmd.entry_period != '0) begin
                           mod_start = 1'b1;
                           state_in  = BS_LOAD_MOD;
                        end else begin
                           phase_zero = 1'b1;
                        end
                     end
                  end
                  CMD_TICK: begin
                     tick_go  = 1'b1;
                     tick_in  = tick_ff + 1'b1;
                     state_in = BS_DUE;
                  end
                  default: begin
                     state_in = BS_IDLE;
                  end
               endcase
            end
         end
         BS_LOAD_MOD: begin
            if (mod_done) begin
               phase_from_mod = 1'b1;
               state_in       = BS_IDLE;
            end
         end
         BS_READ: begin
            if (!rsp_full) begin
               rsp_push       = 1'b1;
               rsp.read_value = rd_valid_ff ? ram_rdata : '0;
               rsp.last       = 1'b1;
               state_in       = BS_IDLE;
            end
         end
         BS_DUE: begin
            due_load = 1'b1;
            state_in = BS_SCAN;
         end
         BS_SCAN: begin
            scan_step = 1'b1;
            if (scan_idx_ff == TW'(NR - 1)) begin
               state_in = BS_EMIT;
            end
         end
         BS_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (found_ff) begin
                  rsp.fire_valid       = 1'b1;
                  rsp.fire_index       = 4'(best_ff);
                  rsp.checkpoint_valid = ckpt;
                  rsp.checkpoint_group = ckpt ? best_group[3:0] : 4'd0;
                  rsp.last             = (remaining == '0);
                  mark_seen            = ckpt;
                  if (remaining == '0) begin
                     state_in = BS_IDLE;
                  end else begin
                     rescan   = 1'b1;
                     state_in = BS_SCAN;
                  end
               end else begin
                  rsp.last = 1'b1;
                  state_in = BS_IDLE;
               end
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         present_ff   <= '0;
         sig_valid_ff <= '0;
         for (int i = 0; i < NR; i++) begin
            period_ff[i] <= '0;
            prio_ff[i]   <= '0;
            group_ff[i]  <= '0;
            phase_ff[i]  <= '0;
         end
      end else begin
         tick_ff <= tick_in;
         if (ram_we) begin
            sig_valid_ff[sig_addr] <= 1'b1;
         end
         if (tick_go) begin
            for (int i = 0; i < NR; i++) begin
               // On wrap to zero every period divides the count again.
               if (tick_ff == '1) begin
                  phase_ff[i] <= '0;
               end else if (({1'b0, phase_ff[i]} + 17'd1) == {1'b0, period_ff[i]}) begin
                  phase_ff[i] <= '0;
               end else begin
                  phase_ff[i] <= phase_ff[i] + 1'b1;
               end
            end
         end
         if (tbl_we) begin
            period_ff[tbl_idx]  <= cmd.entry_period;
            prio_ff[tbl_idx]    <= cmd.entry_priority;
            group_ff[tbl_idx]   <= cmd.entry_group;
            present_ff[tbl_idx] <= cmd.entry_present;
         end
         if (phase_zero) begin
            phase_ff[tbl_idx] <= '0;
         end
         if (phase_from_mod) begin
            phase_ff[load_idx_ff] <= mod_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         load_idx_ff <= tbl_idx;
      end
      if (ram_re) begin
         rd_valid_ff <= sig_valid_ff[sig_addr];
      end
      if (tick_go) begin
         seen_ff <= '0;
      end
      if (mark_seen) begin
         seen_ff[best_group[3:0]] <= 1'b1;
      end
      if (due_load) begin
         for (int i = 0; i < NR; i++) begin
            due_ff[i] <= present_ff[i] && (period_ff[i] != '0) &&
                         (phase_ff[i] == '0) && (i < int'(cfg.runnable_count));
         end
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
      end
      if (scan_step) begin
         scan_idx_ff <= (scan_idx_ff == TW'(NR - 1)) ? '0 : scan_idx_ff + 1'b1;
         if (cand) begin
            found_ff     <= 1'b1;
            best_ff      <= scan_idx_ff;
            best_prio_ff <= prio_ff[scan_idx_ff];
         end
      end
      if (rescan) begin
         due_ff[best_ff] <= 1'b0;
         found_ff        <= 1'b0;
      end
   end
endmodule

FILE: design/periodic_runnable_dispatcher_top.sv
// Periodic runnable dispatcher: a queue-like request port and result port.
// Users: send items on req_push/req_full, take results on rsp_empty/rsp_pop,
// and write enable, signal_count and runnable_count through csr_write_en.
// Each item gives one or more results; the final one carries rsp_last.
// An enabled tick advances the tick counter and yields one result per due
// runnable, highest priority first, or a single result with fire_valid low.
// Status-only items and writes are answered from the idle state, reads after
// a registered signal store read; a load pushes its result when taken but,
// with a nonzero period, holds the back end until the bit-serial remainder
// unit has aligned the new entry to the counter. For a tick the dispatch
// sequencer loads the due flags, scans the table one entry a cycle (up to 16
// entries, as MAX_RUNNABLES is capped at 16) and emits, rescanning per result.
// A two-entry command queue sits between front and back, and a two-entry
// result queue drives the result ports, so input is still taken while a
// result waits. If the receiver stalls, the back end holds its state and the
// command queue fills, then req_full rises. Synchronous reset clears the
// registers, the counter, the table and the signal store (by valid bits).
// Depends on prd_pkg, prd_front, prd_fifo and prd_back.
`timescale 1ns / 1ps
module periodic_runnable_dispatcher_top import prd_pkg::*; #(
   parameter int MAX_SIGNALS   = 64,
   parameter int MAX_RUNNABLES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_write_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_signal_id,
   input  logic [31:0] req_write_value,
   input  logic [3:0]  req_entry_index,
   input  logic [15:0] req_entry_period,
   input  logic [7:0]  req_entry_priority,
   input  logic [7:0]  req_entry_group,
   input  logic        req_entry_present,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_value,
   output logic        rsp_fire_valid,
   output logic [3:0]  rsp_fire_index,
   output logic        rsp_checkpoint_valid,
   output logic [3:0]  rsp_checkpoint_group,
   output logic        rsp_last
);
   cfg_type cfg;
   cmd_type cmd_in, cmd_out;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type rsp_in, rsp_out;
   logic    rsp_push, rsp_full;

   prd_front #(.MAX_SIGNALS(MAX_SIGNALS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_opcode         (req_opcode),
      .req_signal_id      (req_signal_id),
      .req_write_value    (req_write_value),
      .req_entry_index    (req_entry_index),
      .req_entry_period   (req_entry_period),
      .req_entry_priority (req_entry_priority),
      .req_entry_group    (req_entry_group),
      .req_entry_present  (req_entry_present),
      .cfg                (cfg),
      .cmd                (cmd_in),
      .cmd_push           (cmd_push),
      .cmd_full           (cmd_full)
   );

   prd_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_in),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_out),
      .empty   (cmd_empty)
   );

   prd_back #(.MAX_SIGNALS(MAX_SIGNALS), .MAX_RUNNABLES(MAX_RUNNABLES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_in),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   prd_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_in),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_out),
      .empty   (rsp_empty)
   );

   assign rsp_status           = rsp_out.status;
   assign rsp_read_value       = rsp_out.read_value;
   assign rsp_fire_valid       = rsp_out.fire_valid;
   assign rsp_fire_index       = rsp_out.fire_index;
   assign rsp_checkpoint_valid = rsp_out.checkpoint_valid;
   assign rsp_checkpoint_group = rsp_out.checkpoint_group;
   assign rsp_last             = rsp_out.last;
endmodule

FILE: design/prd_checker.sv
// Port-level checker for the dispatcher, bound to the top level.
// Depends on prd_pkg and periodic_runnable_dispatcher_top_macros.svh.
`timescale 1ns / 1ps
`include "periodic_runnable_dispatcher_top_macros.svh"
module prd_checker import prd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_read_value,
   input logic        rsp_fire_valid,
   input logic [3:0]  rsp_fire_index,
   input logic        rsp_checkpoint_valid,
   input logic [3:0]  rsp_checkpoint_group,
   input logic        rsp_last
);
   // A waiting result is never dropped while the receiver holds off.
   `PRD_ASSERT_NEXT(a_rsp_kept, !rsp_empty && !rsp_pop, !rsp_empty, "result lost")
   // A checkpoint only rides on a fire of an enabled tick.
   `PRD_ASSERT_NOW(a_ckpt_fire, !rsp_empty && rsp_checkpoint_valid, rsp_fire_valid && (rsp_status == ST_OK), "checkpoint without fire")
   // Results without a fire carry zero index and group.
   `PRD_ASSERT_NOW(a_nofire_zero, !rsp_empty && !rsp_fire_valid, (rsp_fire_index == 4'd0) && (rsp_checkpoint_group == 4'd0), "stray fire fields")
   // Read data appears only on a successful read, which is a single result.
   `PRD_ASSERT_NOW(a_read_ok, !rsp_empty && (rsp_read_value != 32'd0), (rsp_status == ST_OK) && !rsp_fire_valid && rsp_last, "read data on wrong result")
endmodule

bind periodic_runnable_dispatcher_top prd_checker u_prd_checker (.*);

FILE: test/periodic_runnable_dispatcher_checker.sv
// Scoreboard for the periodic runnable dispatcher: tracks register writes,
// predicts the results of each accepted item and compares what is popped.
// Depends on prd_pkg for the opcode, status and register index codes.
`timescale 1ns / 1ps
module periodic_runnable_dispatcher_checker import prd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_write_data,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_signal_id,
   input  logic [31:0] req_write_value,
   input  logic [3:0]  req_entry_index,
   input  logic [15:0] req_entry_period,
   input  logic [7:0]  req_entry_priority,
   input  logic [7:0]  req_entry_group,
   input  logic        req_entry_present,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_read_value,
   input  logic        rsp_fire_valid,
   input  logic [3:0]  rsp_fire_index,
   input  logic        rsp_checkpoint_valid,
   input  logic [3:0]  rsp_checkpoint_group,
   input  logic        rsp_last,
   output int          errors,
   output int          pending
);
   localparam int NUM_SIGNALS   = 64;
   localparam int NUM_RUNNABLES = 16;

   logic [31:0] signals [NUM_SIGNALS];
   logic [15:0] periods [NUM_RUNNABLES];
   logic [7:0]  priorities [NUM_RUNNABLES];
   logic [7:0]  groups [NUM_RUNNABLES];
   logic        present [NUM_RUNNABLES];
   logic [31:0] ticks;
   logic        cfg_enable;
   logic [6:0]  cfg_signals;
   logic [4:0]  cfg_runnables;
   rsp_type     expected_q [$];

   function automatic rsp_type plain_result(status_type st, logic [31:0] value);
      rsp_type r;
      r = '0;
      r.status = st;
      r.read_value = value;
      r.last = 1'b1;
      return r;
   endfunction

   // Walks the table once per result, taking the highest priority due entry.
   task automatic dispatch_tick();
      logic    due [NUM_RUNNABLES];
      logic    seen [GROUP_LIMIT];
      int      limit;
      int      best;
      int      fired;
      rsp_type r;
      limit = (cfg_runnables > NUM_RUNNABLES) ? NUM_RUNNABLES : int'(cfg_runnables);
      ticks = ticks + 32'd1;
      fired = 0;
      foreach (seen[g]) seen[g] = 1'b0;
      foreach (due[i])
         due[i] = (i < limit) && present[i] && (periods[i] != 16'd0) &&
                  ((ticks % {16'd0, periods[i]}) == 32'd0);
      forever begin
         best = -1;
         for (int i = 0; i < limit; i++)
            if (due[i] && (best < 0 || priorities[i] > priorities[best])) best = i;
         if (best < 0) break;
         due[best] = 1'b0;
         r = '0;
         r.status = ST_OK;
         r.fire_valid = 1'b1;
         r.fire_index = best[3:0];
         if (groups[best] < GROUP_LIMIT && !seen[groups[best]]) begin
            seen[groups[best]] = 1'b1;
            r.checkpoint_valid = 1'b1;
            r.checkpoint_group = groups[best][3:0];
         end
         expected_q.push_back(r);
         fired++;
      end
      if (fired == 0) expected_q.push_back(plain_result(ST_OK, 32'd0));
      else expected_q[expected_q.size() - 1].last = 1'b1;
   endtask

   task automatic predict_item();
      opcode_type op;
      op = opcode_type'(req_opcode);
      if (op == OP_LOAD) begin
         periods[req_entry_index] = req_entry_period;
         priorities[req_entry_index] = req_entry_priority;
         groups[req_entry_index] = req_entry_group;
         present[req_entry_index] = req_entry_present;
         expected_q.push_back(plain_result(ST_OK, 32'd0));
      end else if (!cfg_enable) begin
         expected_q.push_back(plain_result(ST_DISABLED, 32'd0));
      end else if (op == OP_TICK) begin
         dispatch_tick();
      end else if ({1'b0, req_signal_id} >= cfg_signals) begin
         expected_q.push_back(plain_result(ST_RANGE, 32'd0));
      end else if (op == OP_WRITE) begin
         signals[req_signal_id] = req_write_value;
         expected_q.push_back(plain_result(ST_OK, 32'd0));
      end else begin
         expected_q.push_back(plain_result(ST_OK, signals[req_signal_id]));
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         foreach (signals[i]) signals[i] = '0;
         foreach (periods[i]) begin
            periods[i] = '0;
            priorities[i] = '0;
            groups[i] = '0;
            present[i] = 1'b0;
         end
         ticks = '0;
         cfg_enable = 1'b0;
         cfg_signals = '0;
         cfg_runnables = '0;
         expected_q.delete();
         errors <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_ENABLE:         cfg_enable = csr_write_data[0];
               CSR_SIGNAL_COUNT:   cfg_signals = csr_write_data;
               CSR_RUNNABLE_COUNT: cfg_runnables = csr_write_data[4:0];
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            got = '{status_type'(rsp_status), rsp_read_value, rsp_fire_valid,
                    rsp_fire_index, rsp_checkpoint_valid, rsp_checkpoint_group,
                    rsp_last};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors <= errors + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected st=%0d rv=%h fv=%b fi=%0d cv=%b cg=%0d last=%b",
                           $time, want.status, want.read_value, want.fire_valid,
                           want.fire_index, want.checkpoint_valid,
                           want.checkpoint_group, want.last);
                  $display("%0t:          actual   st=%0d rv=%h fv=%b fi=%0d cv=%b cg=%0d last=%b",
                           $time, got.status, got.read_value, got.fire_valid,
                           got.fire_index, got.checkpoint_valid,
                           got.checkpoint_group, got.last);
                  errors <= errors + 1;
               end
            end
         end
         if (req_push && !req_full) predict_item();
      end
      pending <= expected_q.size();
   end
endmodule

FILE: test/tb_periodic_runnable_dispatcher_top.sv
// Stimulus and verdict for the periodic runnable dispatcher.
// Drives directed and random items through several register settings; the
// checker module (periodic_runnable_dispatcher_checker) predicts and compares.
`timescale 1ns / 1ps
module tb_periodic_runnable_dispatcher_top;
   import prd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_write_data = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_opcode = '0;
   logic [5:0]  req_signal_id = '0;
   logic [31:0] req_write_value = '0;
   logic [3:0]  req_entry_index = '0;
   logic [15:0] req_entry_period = '0;
   logic [7:0]  req_entry_priority = '0;
   logic [7:0]  req_entry_group = '0;
   logic        req_entry_present = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_read_value;
   logic        rsp_fire_valid;
   logic [3:0]  rsp_fire_index;
   logic        rsp_checkpoint_valid;
   logic [3:0]  rsp_checkpoint_group;
   logic        rsp_last;
   int          errors;
   int          pending;
   logic        steady = 1'b0;
   logic        hold_req = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   periodic_runnable_dispatcher_top u_dut (.*);
   periodic_runnable_dispatcher_checker u_checker (.*);

   // Result side: random pops, a long hold when asked, always popping while steady.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_pop <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 1'b0;
         end
         rsp_pop <= steady || ($urandom_range(99) >= 38);
      end
   end

   task automatic write_reg(csr_index_type idx, logic [6:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Lets the block drain, including the work a load does after its result.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic configure(logic en, logic [6:0] sig_count, logic [4:0] run_count);
      settle();
      write_reg(CSR_ENABLE, {6'd0, en});
      write_reg(CSR_SIGNAL_COUNT, sig_count);
      write_reg(CSR_RUNNABLE_COUNT, {2'd0, run_count});
      csr_write_en <= 1'b0;
   endtask

   task automatic send(opcode_type op, logic [5:0] sid, logic [31:0] value,
                       logic [3:0] idx, logic [15:0] period, logic [7:0] prio,
                       logic [7:0] grp, logic pres);
      while (!steady && $urandom_range(99) < 38) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= op;
      req_signal_id <= sid;
      req_write_value <= value;
      req_entry_index <= idx;
      req_entry_period <= period;
      req_entry_priority <= prio;
      req_entry_group <= grp;
      req_entry_present <= pres;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic random_item();
      int          pick;
      logic [15:0] period;
      logic [7:0]  prio;
      logic [7:0]  grp;
      pick = $urandom_range(99);
      period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      prio = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
      grp = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(19));
      if (pick < 35)
         send(OP_TICK, 6'($urandom), $urandom, 4'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 1'($urandom));
      else if (pick < 55)
         send(OP_WRITE, 6'($urandom), $urandom, 4'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 1'($urandom));
      else if (pick < 75)
         send(OP_READ, 6'($urandom), $urandom, 4'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 1'($urandom));
      else
         send(OP_LOAD, 6'($urandom), $urandom, 4'($urandom), period, prio, grp,
              $urandom_range(4) != 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Disabled block: ticks and accesses fail, loads still answer.
      send(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      send(OP_WRITE, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      send(OP_LOAD, 0, 0, 4'd0, 16'd1, 8'd5, 8'd3, 1'b1);
      send(OP_LOAD, 0, 0, 4'd15, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
      send(OP_LOAD, 0, 0, 4'd1, 16'd1, 8'd5, 8'd3, 1'b1);
      send(OP_LOAD, 0, 0, 4'd2, 16'd2, 8'd9, 8'd20, 1'b1);
      send(OP_LOAD, 0, 0, 4'd3, 16'd0, 8'd9, 8'd1, 1'b1);
      send(OP_LOAD, 0, 0, 4'd4, 16'd1, 8'd9, 8'd1, 1'b0);
      send(OP_LOAD, 0, 0, 4'd14, 16'd1, 8'd0, 8'd15, 1'b1);

      configure(1'b1, 7'd64, 5'd16);
      send(OP_WRITE, 6'd0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
      send(OP_WRITE, 6'd63, 32'hA5A5_5A5A, 0, 0, 0, 0, 0);
      send(OP_READ, 6'd0, 0, 0, 0, 0, 0, 0);
      send(OP_READ, 6'd63, 0, 0, 0, 0, 0, 0);
      send(OP_READ, 6'd10, 0, 0, 0, 0, 0, 0);
      send(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      send(OP_TICK, 0, 0, 0, 0, 0, 0, 0);

      // Out-of-range ids and saturated runnable count.
      configure(1'b1, 7'd0, 5'd31);
      send(OP_READ, 6'd0, 0, 0, 0, 0, 0, 0);
      send(OP_WRITE, 6'd63, 32'h1, 0, 0, 0, 0, 0);
      send(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      configure(1'b1, 7'd127, 5'd0);
      send(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      send(OP_READ, 6'd63, 0, 0, 0, 0, 0, 0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(1'b1, 7'd64, 5'd16);
            1: configure(1'b1, 7'd127, 5'd31);
            2: configure(1'b0, 7'd64, 5'd16);
            3: configure(1'b1, 7'd0, 5'd0);
            default: configure(1'b1, 7'($urandom_range(127)), 5'($urandom_range(31)));
         endcase
         steady = (phase == 4);
         if (phase == 5) hold_req = 1'b1;
         repeat (55) random_item();
      end
      steady = 1'b0;
      settle();
      if (errors == 0 && pending == 0) begin
         $display("periodic_runnable_dispatcher_top test passed");
      end else begin
         $display("periodic_runnable_dispatcher_top test failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("periodic_runnable_dispatcher_top test failed");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+design
design/prd_pkg.sv
design/prd_ram.sv
design/prd_fifo.sv
design/prd_modu.sv
design/prd_front.sv
design/prd_back.sv
design/periodic_runnable_dispatcher_top.sv
design/prd_checker.sv
test/periodic_runnable_dispatcher_checker.sv
test/tb_periodic_runnable_dispatcher_top.sv
